// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define VMNE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define VMNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define VMNE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/vmne_pkg.sv
package vmne_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP,
    ST_EVAL,
    ST_NORM,
    ST_CROSS,
    ST_NCHK,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Which vector the normalizer is working on
  typedef enum logic [1:0] {
    PH_DX,
    PH_DY,
    PH_N
  } phase_t;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_COORD_BITS  = 32;
  localparam int DEF_NORMAL_BITS = 16;

  // Configuration port
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Fixed-point working widths
  localparam int FIT_SHIFT = 30;          // magnitudes are brought below 2^30
  localparam int MAG_W     = FIT_SHIFT;
  localparam int NV_W      = 62;          // cross product magnitude
  localparam int MUL_W     = 32;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 31;
  localparam int ROOT_STEPS = 32;

endpackage

// File: design/vmne_line_store.sv
module vmne_line_store #(
  parameter int DEPTH  = 2051,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/vertex_map_normal_estimator_top.sv
// Items that yield no normal leave the sequencer idle; in_ready stays high.
// A normal with a center depth that is not positive skips the normalizer; one with a zero
// cross product skips the square root; else the path runs through the nine line store
// reads, the square root and three divides, one per normal component.
// One item is in work at a time; in_ready returns as its result enters the output register.
// Reset (rst, synchronous) loads width 640 and height 480 and clears all positions.
module vertex_map_normal_estimator_top #(
  parameter int MAX_WIDTH   = vmne_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = vmne_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_BITS  = vmne_pkg::DEF_COORD_BITS,
  parameter int NORMAL_BITS = vmne_pkg::DEF_NORMAL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vmne_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmne_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic signed [COORD_BITS-1:0]       vertex_x,
  input  logic signed [COORD_BITS-1:0]       vertex_y,
  input  logic signed [COORD_BITS-1:0]       vertex_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [NORMAL_BITS-1:0]      normal_x,
  output logic signed [NORMAL_BITS-1:0]      normal_y,
  output logic signed [NORMAL_BITS-1:0]      normal_z,
  output logic                               invalid,
  output logic                               frame_end
);
  import vmne_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int SPAN_W = $clog2(LINE_DEPTH + 1);
  localparam int OFF_W  = SPAN_W + 2;
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int GRAD_W = COORD_BITS + 4;
  localparam int DATA_W = 3 * COORD_BITS;
  localparam int QB     = NORMAL_BITS + 1;
  localparam int NUM_W  = MAG_W + NORMAL_BITS;
  localparam int DC_W   = $clog2(QB + 2);
  localparam logic [QB-1:0] SCALE = QB'(1) << (NORMAL_BITS - 1);

  // ---------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped frame size and ring span
  logic [WD_W-1:0]   eff_w;
  logic [HD_W-1:0]   eff_h;
  logic [SPAN_W-1:0] span;

  always_comb begin
    if (image_width < CFG_W'(3)) eff_w = WD_W'(3);
    else if (32'(image_width) > 32'(MAX_WIDTH)) eff_w = WD_W'(MAX_WIDTH);
    else eff_w = WD_W'(image_width);
    if (image_height < CFG_W'(3)) eff_h = HD_W'(3);
    else if (32'(image_height) > 32'(MAX_HEIGHT)) eff_h = HD_W'(MAX_HEIGHT);
    else eff_h = HD_W'(image_height);
    span = (SPAN_W'(eff_w) << 1) + SPAN_W'(3);
  end

  function automatic logic [ADDR_W-1:0] ptr_inc(logic [ADDR_W-1:0] p,
                                                logic [SPAN_W-1:0] s);
    logic [SPAN_W-1:0] n;
    n = SPAN_W'(p) + SPAN_W'(1);
    return (n == s) ? '0 : ADDR_W'(n);
  endfunction

  // Sobel tap term: pos 0 subtracts, 2 adds, 1 drops; other == 1 doubles
  function automatic logic signed [GRAD_W-1:0] tap_term(logic signed [COORD_BITS-1:0] v,
                                                        logic [1:0] pos, logic [1:0] other);
    logic signed [GRAD_W-1:0] e;
    e = GRAD_W'(v);
    if (other == 2'd1) e = e <<< 1;
    case (pos)
      2'd0:    return -e;
      2'd2:    return e;
      default: return '0;
    endcase
  endfunction

  function automatic logic [NV_W-1:0] grad_mag(logic signed [GRAD_W-1:0] v);
    logic signed [GRAD_W-1:0] a;
    a = (v < 0) ? -v : v;
    return NV_W'($unsigned(a));
  endfunction

  function automatic logic signed [MUL_W-1:0] with_sign(logic [MAG_W-1:0] m, logic neg);
    logic signed [MUL_W-1:0] s;
    s = $signed(MUL_W'(m));
    return neg ? -s : s;
  endfunction

  // ---------------------------------------------------------------
  // State
  state_t state, state_next;
  phase_t phase;
  logic   grow;

  logic [WD_W-1:0]   in_col, out_col, q_col;
  logic [HD_W-1:0]   in_row, out_row, q_row;
  logic [ADDR_W-1:0] in_ptr, out_ptr, q_ptr;
  logic              q_end;

  logic [1:0] iss_i, iss_j, rd_i, rd_j;
  logic       iss_done, rd_vld;
  logic signed [GRAD_W-1:0] gx [3];
  logic signed [GRAD_W-1:0] gy [3];
  logic signed [COORD_BITS-1:0] center_z;

  logic [NV_W-1:0] nv [3];
  logic            ns [3];
  logic signed [MUL_W-1:0] dxs [3];
  logic signed [MUL_W-1:0] dys [3];
  logic [2:0] mstep;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod, acc;

  logic [SUM_W-1:0] sq_v, sq_r, sq_b;
  logic [4:0]       sq_cnt;

  logic [1:0]        div_k;
  logic [DC_W-1:0]   div_cnt;
  logic [ROOT_W-1:0] div_rem;
  logic [QB-1:0]     div_low;

  logic [NORMAL_BITS-1:0] res [3];
  logic                   res_inv;

  // ---------------------------------------------------------------
  // Input decode for the item on the port
  logic accept, pix, restart, past_lead, o_end, emit, flush_live;
  logic [WD_W-1:0]   c_col, o_col;
  logic [HD_W-1:0]   c_row, o_row;
  logic [ADDR_W-1:0] c_ptr, o_ptr;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    pix        = (cmd == CMD_PIXEL);
    restart    = pix && (in_row >= eff_h);
    c_col      = restart ? '0 : in_col;
    c_row      = restart ? '0 : in_row;
    c_ptr      = restart ? '0 : in_ptr;
    o_col      = restart ? '0 : out_col;
    o_row      = restart ? '0 : out_row;
    o_ptr      = restart ? '0 : out_ptr;
    past_lead  = (c_row >= HD_W'(2)) || (c_row == HD_W'(1) && c_col != '0);
    o_end      = (o_row == eff_h - HD_W'(1)) && (o_col == eff_w - WD_W'(1));
    flush_live = !pix && (in_row >= eff_h);
    emit       = (o_row < eff_h) && (pix ? past_lead : flush_live);
  end

  // ---------------------------------------------------------------
  // Line store: one word holds x, y and z of a pixel
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  vmne_line_store #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && pix),
    .waddr (c_ptr),
    .wdata ({vertex_z, vertex_y, vertex_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // tap address: center ring slot plus clamped row and column offset
  always_comb begin
    logic signed [OFF_W-1:0] off, idx_s, sw, ws;
    ws  = $signed(OFF_W'(eff_w));
    sw  = $signed(OFF_W'(span));
    off = '0;
    if (iss_i == 2'd0 && q_row != '0) off = off - ws;
    if (iss_i == 2'd2 && q_row != eff_h - HD_W'(1)) off = off + ws;
    if (iss_j == 2'd0 && q_col != '0) off = off - OFF_W'(1);
    if (iss_j == 2'd2 && q_col != eff_w - WD_W'(1)) off = off + OFF_W'(1);
    idx_s = $signed(OFF_W'(q_ptr)) + off;
    if (idx_s < 0) idx_s = idx_s + sw;
    else if (idx_s >= sw) idx_s = idx_s - sw;
    raddr = ADDR_W'(idx_s);
  end

  // ---------------------------------------------------------------
  // Shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_CROSS) begin
      case (mstep)
        3'd0: begin mul_a = dys[1]; mul_b = dxs[2]; end
        3'd1: begin mul_a = dys[2]; mul_b = dxs[1]; end
        3'd2: begin mul_a = dys[2]; mul_b = dxs[0]; end
        3'd3: begin mul_a = dys[0]; mul_b = dxs[2]; end
        3'd4: begin mul_a = dys[0]; mul_b = dxs[1]; end
        3'd5: begin mul_a = dys[1]; mul_b = dxs[0]; end
        default: ;
      endcase
    end else if (mstep < 3'd3) begin
      mul_a = $signed(MUL_W'(nv[mstep[1:0]][MAG_W-1:0]));
      mul_b = mul_a;
    end
  end

  // normalizer and divider helpers
  logic [NV_W-1:0] nv_top;
  logic            nv_big, nv_small;
  logic [NUM_W-1:0] div_num;
  logic [ROOT_W:0]  div_trial;
  logic [QB-1:0]    mm;
  logic [NORMAL_BITS-1:0] res_val;

  always_comb begin
    nv_top    = nv[0] | nv[1] | nv[2];
    nv_big    = |nv_top[NV_W-1:FIT_SHIFT];
    nv_small  = !nv_top[FIT_SHIFT-1];
    div_num   = (NUM_W'(nv[div_k][MAG_W-1:0]) << (NORMAL_BITS - 1))
              + NUM_W'(sq_r[ROOT_W-1:1]);
    div_trial = {div_rem, div_low[QB-1]};
    mm = (div_low > SCALE) ? SCALE : div_low;
    if (ns[div_k]) res_val = NORMAL_BITS'(-$signed({1'b0, mm}));
    else if (mm == SCALE) res_val = NORMAL_BITS'(SCALE - QB'(1));
    else res_val = NORMAL_BITS'(mm);
  end

  // ---------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && emit) state_next = ST_TAP;
      ST_TAP:   if (rd_vld && rd_i == 2'd2 && rd_j == 2'd2) state_next = ST_EVAL;
      ST_EVAL:  state_next = (center_z <= 0) ? ST_DONE : ST_NORM;
      ST_NORM: begin
        if (!nv_big && !(grow && nv_small)) begin
          case (phase)
            PH_DY:   state_next = ST_CROSS;
            PH_N:    state_next = ST_SQ;
            default: ;
          endcase
        end
      end
      ST_CROSS: if (mstep == 3'd6) state_next = ST_NCHK;
      ST_NCHK:  state_next = (nv_top == '0) ? ST_DONE : ST_NORM;
      ST_SQ:    if (mstep == 3'd3) state_next = ST_SQRT;
      ST_SQRT:  if (sq_cnt == 5'(ROOT_STEPS - 1)) state_next = ST_DIV;
      ST_DIV:   if (div_cnt == DC_W'(QB + 1) && div_k == 2'd2) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // ---------------------------------------------------------------
  // Frame position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      in_ptr  <= '0;
      out_col <= '0;
      out_row <= '0;
      out_ptr <= '0;
    end else if (accept) begin
      if (pix) begin
        if (c_col == eff_w - WD_W'(1)) begin
          in_col <= '0;
          in_row <= c_row + HD_W'(1);
        end else begin
          in_col <= c_col + WD_W'(1);
          in_row <= c_row;
        end
        in_ptr <= ptr_inc(c_ptr, span);
      end
      if ((flush_live && (out_row >= eff_h || o_end))) begin
        in_col  <= '0;
        in_row  <= '0;
        in_ptr  <= '0;
        out_col <= '0;
        out_row <= '0;
        out_ptr <= '0;
      end else if (emit) begin
        if (o_col == eff_w - WD_W'(1)) begin
          out_col <= '0;
          out_row <= o_row + HD_W'(1);
        end else begin
          out_col <= o_col + WD_W'(1);
          out_row <= o_row;
        end
        out_ptr <= ptr_inc(o_ptr, span);
      end else begin
        out_col <= o_col;
        out_row <= o_row;
        out_ptr <= o_ptr;
      end
    end
  end

  // ---------------------------------------------------------------
  // Datapath sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q_col    <= o_col;
        q_row    <= o_row;
        q_ptr    <= o_ptr;
        q_end    <= o_end;
        iss_i    <= '0;
        iss_j    <= '0;
        iss_done <= 1'b0;
        rd_vld   <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          gx[k] <= '0;
          gy[k] <= '0;
        end
      end

      // gather the 3x3 window, one read a cycle
      ST_TAP: begin
        rd_vld <= !iss_done;
        rd_i   <= iss_i;
        rd_j   <= iss_j;
        if (!iss_done) begin
          if (iss_j == 2'd2) begin
            iss_j <= '0;
            iss_i <= iss_i + 2'd1;
            if (iss_i == 2'd2) iss_done <= 1'b1;
          end else begin
            iss_j <= iss_j + 2'd1;
          end
        end
        if (rd_vld) begin
          for (int k = 0; k < 3; k++) begin
            gx[k] <= gx[k] + tap_term(rdata[k*COORD_BITS +: COORD_BITS], rd_j, rd_i);
            gy[k] <= gy[k] + tap_term(rdata[k*COORD_BITS +: COORD_BITS], rd_i, rd_j);
          end
          if (rd_i == 2'd1 && rd_j == 2'd1) center_z <= rdata[2*COORD_BITS +: COORD_BITS];
        end
      end

      ST_EVAL: begin
        res_inv <= (center_z <= 0);
        for (int k = 0; k < 3; k++) begin
          res[k] <= '0;
          nv[k]  <= grad_mag(gx[k]);
          ns[k]  <= gx[k] < 0;
        end
        phase <= PH_DX;
        grow  <= 1'b0;
      end

      // one-bit shift per cycle until the top bit sits below 2^30 (and, for n, at 2^29)
      ST_NORM: begin
        mstep <= '0;
        sq_v  <= '0;
        if (nv_big) begin
          for (int k = 0; k < 3; k++) nv[k] <= nv[k] >> 1;
        end else if (grow && nv_small) begin
          for (int k = 0; k < 3; k++) nv[k] <= nv[k] << 1;
        end else if (phase == PH_DX) begin
          for (int k = 0; k < 3; k++) begin
            dxs[k] <= with_sign(nv[k][MAG_W-1:0], ns[k]);
            nv[k]  <= grad_mag(gy[k]);
            ns[k]  <= gy[k] < 0;
          end
          phase <= PH_DY;
        end else if (phase == PH_DY) begin
          for (int k = 0; k < 3; k++) dys[k] <= with_sign(nv[k][MAG_W-1:0], ns[k]);
        end
      end

      // n = dy x dx, one product a cycle
      ST_CROSS: begin
        mstep <= mstep + 3'd1;
        prod  <= mul_a * mul_b;
        if (mstep != 3'd0) begin
          if (!mstep[0]) begin
            nv[mstep[2:1] - 2'd1] <= NV_W'($unsigned((acc - prod < 0) ? prod - acc
                                                                     : acc - prod));
            ns[mstep[2:1] - 2'd1] <= (acc - prod) < 0;
          end else begin
            acc <= prod;
          end
        end
      end

      ST_NCHK: begin
        phase <= PH_N;
        grow  <= 1'b1;
      end

      // sum of squares
      ST_SQ: begin
        mstep <= mstep + 3'd1;
        prod  <= mul_a * mul_b;
        if (mstep != 3'd0) sq_v <= sq_v + SUM_W'($unsigned(prod));
        sq_r   <= '0;
        sq_b   <= SUM_W'(1) << (SUM_W - 2);
        sq_cnt <= '0;
      end

      // bit-pair square root
      ST_SQRT: begin
        sq_cnt <= sq_cnt + 5'd1;
        sq_b   <= sq_b >> 2;
        if (sq_v >= sq_r + sq_b) begin
          sq_v <= sq_v - (sq_r + sq_b);
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        div_k   <= '0;
        div_cnt <= '0;
      end

      // rounded divide of each magnitude by the length
      ST_DIV: begin
        if (div_cnt == '0) begin
          div_rem <= ROOT_W'(div_num >> QB);
          div_low <= div_num[QB-1:0];
          div_cnt <= div_cnt + DC_W'(1);
        end else if (div_cnt != DC_W'(QB + 1)) begin
          if (div_trial >= {1'b0, sq_r[ROOT_W-1:0]}) begin
            div_rem <= ROOT_W'(div_trial - {1'b0, sq_r[ROOT_W-1:0]});
            div_low <= {div_low[QB-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[ROOT_W-1:0];
            div_low <= {div_low[QB-2:0], 1'b0};
          end
          div_cnt <= div_cnt + DC_W'(1);
        end else begin
          res[div_k] <= res_val;
          div_k      <= div_k + 2'd1;
          div_cnt    <= '0;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      normal_x  <= res[0];
      normal_y  <= res[1];
      normal_z  <= res[2];
      invalid   <= res_inv;
      frame_end <= q_end;
    end
  end

endmodule

// File: design/vmne_checker.sv
`include "assert_macros.svh"

module vmne_checker #(
  parameter int NORMAL_BITS = vmne_pkg::DEF_NORMAL_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [NORMAL_BITS-1:0] normal_x,
  input logic signed [NORMAL_BITS-1:0] normal_y,
  input logic signed [NORMAL_BITS-1:0] normal_z,
  input logic                          invalid,
  input logic                          frame_end
);

  // a stalled result holds its payload
  `VMNE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(invalid) && $stable(frame_end), "result changed while stalled")

  // a bad-depth pixel carries a zero normal
  `VMNE_ASSERT_NOW(a_invalid_zero, clk, rst, out_valid && invalid, normal_x == 0 && normal_y == 0 && normal_z == 0, "invalid result with nonzero normal")

  // reset leaves no result pending
  `VMNE_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "result pending after reset")

endmodule

bind vertex_map_normal_estimator_top vmne_checker #(.NORMAL_BITS(NORMAL_BITS)) u_vmne_checker (.*);
